// File: hw/rtl/lpfb_pkg.sv
package lpfb_pkg;

  // Screen geometry and frame store size
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  // Largest count a single line can reach on screen, saturated to a byte
  localparam int MAX_DIM       = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int MAX_COUNT     = (MAX_DIM > 255) ? 255 : MAX_DIM;

  // Coordinate and Bresenham arithmetic widths
  localparam int COORD_W = 9;
  localparam int DELTA_W = 9;
  localparam int ERR_W   = 10;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item kinds on the input tuser
  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Colour modes; the unused code behaves as clear
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  // Commands held in the queue
  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Operations issued into the memory pipeline
  typedef enum logic [1:0] {
    OP_PIX   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    cmd_e                       kind;
    logic                       steep;
    logic signed [COORD_W-1:0]  u0;
    logic signed [COORD_W-1:0]  v0;
    logic [DELTA_W-1:0]         dx;
    logic [DELTA_W-1:0]         dy;
    logic                       ystep_neg;
    logic [1:0]                 mode;
    logic                       rd_ok;
    logic [ADDR_W-1:0]          rd_addr;
  } cmd_t;

  typedef struct packed {
    op_e               kind;
    logic              on;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [1:0]        mode;
    logic              last;
  } op_t;

endpackage

// File: hw/rtl/lpfb_queue.sv
module lpfb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpfb_pkg::cmd_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output lpfb_pkg::cmd_t pop_data_o,
  input  logic           pop_i
);
  import lpfb_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/lpfb_front.sv
module lpfb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [1:0]            kind_i,
  input  logic signed [8:0]     x_start_i,
  input  logic signed [8:0]     y_start_i,
  input  logic signed [8:0]     x_end_i,
  input  logic signed [8:0]     y_end_i,
  input  logic [1:0]            color_mode_i,
  input  logic [2:0]            read_page_i,
  input  logic [6:0]            read_column_i,
  input  logic                  init_busy_i,
  output logic                  q_valid_o,
  output lpfb_pkg::cmd_t        q_cmd_o,
  input  logic                  q_ready_i
);
  import lpfb_pkg::*;

  logic                      vld_q, vld_d;
  cmd_t                      cmd_q, cmd_d;
  logic                      take;
  logic signed [ERR_W-1:0]   ddx, ddy, dm, dn;
  logic [ERR_W-1:0]          adx_w, ady_w;
  logic [DELTA_W-1:0]        adx, ady;
  logic                      steep;

  assign s_ready_o = !init_busy_i && (!vld_q || q_ready_i);
  assign take      = s_valid_i && s_ready_o;
  assign q_valid_o = vld_q;
  assign q_cmd_o   = cmd_q;

  // Line setup: pick the major axis, order the endpoints, derive the deltas
  always_comb begin
    ddx   = ERR_W'(x_end_i) - ERR_W'(x_start_i);
    ddy   = ERR_W'(y_end_i) - ERR_W'(y_start_i);
    adx_w = ddx[ERR_W-1] ? ERR_W'(-ddx) : ERR_W'(ddx);
    ady_w = ddy[ERR_W-1] ? ERR_W'(-ddy) : ERR_W'(ddy);
    adx   = adx_w[DELTA_W-1:0];
    ady   = ady_w[DELTA_W-1:0];
    steep = ady > adx;
    dm    = steep ? ddy : ddx;
    dn    = steep ? ddx : ddy;

    cmd_d         = '0;
    cmd_d.steep   = steep;
    cmd_d.dx      = steep ? ady : adx;
    cmd_d.dy      = steep ? adx : ady;
    if (dm[ERR_W-1]) begin
      cmd_d.u0        = steep ? y_end_i : x_end_i;
      cmd_d.v0        = steep ? x_end_i : y_end_i;
      cmd_d.ystep_neg = !dn[ERR_W-1];
    end else begin
      cmd_d.u0        = steep ? y_start_i : x_start_i;
      cmd_d.v0        = steep ? x_start_i : y_start_i;
      cmd_d.ystep_neg = !(!dn[ERR_W-1] && (dn != '0));
    end
    cmd_d.mode    = ((color_mode_i == MODE_SET) || (color_mode_i == MODE_INVERT))
                    ? color_mode_i : MODE_CLEAR;
    cmd_d.rd_ok   = (32'(read_page_i) < PAGE_COUNT) && (32'(read_column_i) < SCREEN_WIDTH);
    cmd_d.rd_addr = ADDR_W'(32'(read_page_i) * SCREEN_WIDTH + 32'(read_column_i));

    unique case (kind_e'(kind_i))
      KIND_DRAW:  cmd_d.kind = CMD_DRAW;
      KIND_READ:  cmd_d.kind = CMD_READ;
      KIND_CLEAR: cmd_d.kind = CMD_CLEAR;
      KIND_NOP: begin
        // answered as a read that finds nothing
        cmd_d.kind  = CMD_READ;
        cmd_d.rd_ok = 1'b0;
      end
    endcase
  end

  assign vld_d = (vld_q && !q_ready_i) || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: hw/rtl/lpfb_back.sv
module lpfb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lpfb_pkg::cmd_t q_cmd_i,
  output logic           q_ready_o,
  output logic           init_busy_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [15:0]    m_data_o
);
  import lpfb_pkg::*;

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [ADDR_W-1:0]         clr_addr_q, clr_addr_d;

  // walker registers
  logic signed [COORD_W-1:0] u_q, u_d, v_q, v_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic [DELTA_W-1:0]        left_q, left_d, dx_q, dx_d, dy_q, dy_d;
  logic                      ystep_neg_q, ystep_neg_d, steep_q, steep_d;
  logic [1:0]                mode_q, mode_d;

  // pipeline registers
  logic                      s1_valid_q;
  op_t                       s1_op_q;
  op_t                       issue_op;
  logic                      issue_valid;
  logic [7:0]                frame_mem [STORE_BYTES];
  logic [7:0]                rdata_q;
  logic                      wr_valid_q;
  logic [ADDR_W-1:0]         wr_addr_q;
  logic [7:0]                wr_data_q;
  logic [7:0]                cnt_q, cnt_next;
  logic                      out_valid_q;
  logic [15:0]               out_data_q;

  logic                      adv, we, s1_last;
  logic [7:0]                cur, new_byte, wdata;
  logic signed [COORD_W-1:0] col, row;
  logic signed [ERR_W-1:0]   e1;
  logic                      pix_on;
  logic [ADDR_W-1:0]         pix_addr;
  logic [15:0]               result;

  assign s1_last     = s1_valid_q && s1_op_q.last;
  assign adv         = !(s1_last && out_valid_q && !m_ready_i);
  assign init_busy_o = (state_q == ST_INIT);
  assign q_ready_o   = adv && (state_q == ST_IDLE);
  assign m_valid_o   = out_valid_q;
  assign m_data_o    = out_data_q;

  // current pixel of the walk
  always_comb begin
    col      = steep_q ? v_q : u_q;
    row      = steep_q ? u_q : v_q;
    pix_on   = !col[COORD_W-1] && (32'(col[7:0]) < SCREEN_WIDTH) &&
               !row[COORD_W-1] && (32'(row[7:0]) < SCREEN_HEIGHT);
    pix_addr = ADDR_W'(32'(row[7:3]) * SCREEN_WIDTH + 32'(col[7:0]));
    e1       = err_q - ERR_W'(dy_q);
  end

  // sequencer: issue one operation per cycle into the memory pipeline unless a stalled result holds it
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    u_d         = u_q;
    v_d         = v_q;
    err_d       = err_q;
    left_d      = left_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    ystep_neg_d = ystep_neg_q;
    steep_d     = steep_q;
    mode_d      = mode_q;
    issue_valid = 1'b0;
    issue_op    = '0;
    issue_op.mask = 8'd1 << row[2:0];

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        issue_valid   = 1'b1;
        issue_op.kind = OP_CLEAR;
        issue_op.on   = 1'b1;
        issue_op.addr = clr_addr_q;
        issue_op.last = (state_q == ST_CLEAR) && (clr_addr_q == ADDR_W'(STORE_BYTES - 1));
        clr_addr_d    = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.kind)
            CMD_READ: begin
              issue_valid   = 1'b1;
              issue_op.kind = OP_READ;
              issue_op.on   = q_cmd_i.rd_ok;
              issue_op.addr = q_cmd_i.rd_addr;
              issue_op.last = 1'b1;
            end
            CMD_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            CMD_DRAW: begin
              u_d         = q_cmd_i.u0;
              v_d         = q_cmd_i.v0;
              dx_d        = q_cmd_i.dx;
              dy_d        = q_cmd_i.dy;
              left_d      = q_cmd_i.dx;
              err_d       = ERR_W'(q_cmd_i.dx >> 1);
              ystep_neg_d = q_cmd_i.ystep_neg;
              steep_d     = q_cmd_i.steep;
              mode_d      = q_cmd_i.mode;
              state_d     = ST_DRAW;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DRAW: begin
        issue_valid   = 1'b1;
        issue_op.kind = OP_PIX;
        issue_op.on   = pix_on;
        issue_op.addr = pix_addr;
        issue_op.mode = mode_q;
        issue_op.last = (left_q == '0);
        u_d           = u_q + COORD_W'(1);
        left_d        = left_q - DELTA_W'(1);
        if (e1[ERR_W-1]) begin
          v_d   = ystep_neg_q ? v_q - COORD_W'(1) : v_q + COORD_W'(1);
          err_d = e1 + ERR_W'(dx_q);
        end else begin
          err_d = e1;
        end
        if (left_q == '0) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // write stage: modify the byte registered in rdata_q, forward the previous write
  always_comb begin
    cur = (wr_valid_q && (wr_addr_q == s1_op_q.addr)) ? wr_data_q : rdata_q;
    if (s1_op_q.mode == MODE_SET) begin
      new_byte = cur | s1_op_q.mask;
    end else if (s1_op_q.mode == MODE_INVERT) begin
      new_byte = cur ^ s1_op_q.mask;
    end else begin
      new_byte = cur & ~s1_op_q.mask;
    end
    cnt_next = (s1_op_q.on && (cnt_q != 8'hFF)) ? cnt_q + 8'd1 : cnt_q;
    we       = 1'b0;
    wdata    = new_byte;
    result   = '0;
    unique case (s1_op_q.kind)
      OP_PIX: begin
        we     = adv && s1_valid_q && s1_op_q.on;
        result = {cnt_next, 8'd0};
      end
      OP_CLEAR: begin
        we     = adv && s1_valid_q;
        wdata  = 8'd0;
      end
      OP_READ: begin
        result = {8'd0, s1_op_q.on ? cur : 8'd0};
      end
      default: begin
        we     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= frame_mem[issue_op.addr];
    end
    if (we) begin
      frame_mem[s1_op_q.addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      wr_valid_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q    <= state_d;
        clr_addr_q <= clr_addr_d;
        s1_valid_q <= issue_valid;
        wr_valid_q <= we;
        if (s1_valid_q && (s1_op_q.kind == OP_PIX)) begin
          cnt_q <= s1_op_q.last ? 8'd0 : cnt_next;
        end
      end
      if (adv && s1_last) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= issue_op;
      wr_addr_q   <= s1_op_q.addr;
      wr_data_q   <= wdata;
      u_q         <= u_d;
      v_q         <= v_d;
      err_q       <= err_d;
      left_q      <= left_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      ystep_neg_q <= ystep_neg_d;
      steep_q     <= steep_d;
      mode_q      <= mode_d;
    end
    if (adv && s1_last) begin
      out_data_q <= result;
    end
  end

endmodule

// File: hw/rtl/bresenham_line_to_paged_framebuffer.sv
// Channel   Dir  Signals                           Contents
// s_axis    in   tvalid tready tdata[47:0] tuser   one item per beat: draw, read, clear or spare (empty read)
// m_axis    out  tvalid tready tdata[15:0]         one result beat per item
//
// A draw walks the line's major axis: the walker issues one pixel read-modify-write per
// cycle into the frame memory (one read, one write port) unless a stalled result holds it.
// A clear sweeps the memory, one byte a cycle under the same condition (1024 bytes at the
// default size), as does the clearing pass after reset, during which s_axis_tready stays
// low. Reset is asynchronous and active low.
// The front accepts and sets up the next beat while the back draws; a stalled result
// beat holds the back with one more item in its pipeline, while up to three further
// items wait in the front register and the queue.
module bresenham_line_to_paged_framebuffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27], color_mode[37:36],
  // read_page[40:38], read_column[47:41]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_byte[7:0], pixels_written[15:8]
  output logic [15:0] m_axis_tdata
);
  import lpfb_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;
  logic init_busy;

  // Front: take the beat, classify it and work out the line setup
  lpfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .x_start_i     ($signed(s_axis_tdata[8:0])),
    .y_start_i     ($signed(s_axis_tdata[17:9])),
    .x_end_i       ($signed(s_axis_tdata[26:18])),
    .y_end_i       ($signed(s_axis_tdata[35:27])),
    .color_mode_i  (s_axis_tdata[37:36]),
    .read_page_i   (s_axis_tdata[40:38]),
    .read_column_i (s_axis_tdata[47:41]),
    .init_busy_i   (init_busy),
    .q_valid_o     (push_valid),
    .q_cmd_o       (push_cmd),
    .q_ready_i     (push_ready)
  );

  // Short command queue: lets the front run ahead of a long draw or clear
  lpfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_data_i  (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_cmd),
    .pop_i        (pop_ready)
  );

  // Back: walk the line, sweep clears, read bytes; owns the frame memory
  lpfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_cmd_i     (pop_cmd),
    .q_ready_o   (pop_ready),
    .init_busy_o (init_busy),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

// File: hw/rtl/lpfb_checker.sv
module lpfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import lpfb_pkg::*;

  // held result beat stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // no input taken in the first cycle after reset: the clearing pass runs
  a_init_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // a result carries either a byte or a count, never both
  a_one_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[15:8] == 8'd0))
    else $error("result carries both a byte and a count");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[15:8]) <= MAX_COUNT))
    else $error("pixel count beyond screen size");

endmodule

bind bresenham_line_to_paged_framebuffer lpfb_checker u_lpfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lpfb_pkg::*;

  // Spare colour code: the block treats it as a clear
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_JOBS = 800;
  localparam int SHOW_LIMIT  = 50;

  typedef struct {
    kind_e                      kind;
    logic signed [COORD_W-1:0]  xs;
    logic signed [COORD_W-1:0]  ys;
    logic signed [COORD_W-1:0]  xe;
    logic signed [COORD_W-1:0]  ye;
    logic [1:0]                 mode;
    logic [2:0]                 page;
    logic [6:0]                 column;
    bit                         drain;  // hold this beat back until every result is home
  } job_t;

  typedef struct {
    logic [7:0] read_byte;
    logic [7:0] pixels;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27], color_mode[37:36],
  // read_page[40:38], read_column[47:41]
  logic [47:0] s_axis_tdata = '0;
  // kind[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // read_byte[7:0], pixels_written[15:8]
  logic [15:0] m_axis_tdata;

  // Shadow copy of the paged frame store, kept in acceptance order
  logic [7:0] frame_model [STORE_BYTES];

  job_t   job_q[$];
  reply_t due_results[$];
  job_t   live_job;
  reply_t want;

  int  errors       = 0;
  int  jobs_total   = 0;
  int  jobs_taken   = 0;
  int  results_seen = 0;
  int  last_x       = 0;
  int  last_y       = 0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;
  int  tx_gap       = 0;
  bit  tx_burst     = 1'b0;
  int  rx_gap       = 0;
  bit  rx_burst     = 1'b0;
  bit  rx_on_valid  = 1'b0;
  int  hold_left    = 0;

  bresenham_line_to_paged_framebuffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Give up long after the slowest legal run (every beat a full clear plus both stalls)
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic flag_error(string what);
    errors++;
    if (errors <= SHOW_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Apply a colour to one pixel; off-screen pixels are skipped and not counted
  function automatic int paint_pixel(int col, int row, logic [1:0] mode);
    int         addr;
    logic [7:0] bitmask;
    if (col < 0 || col >= SCREEN_WIDTH || row < 0 || row >= SCREEN_HEIGHT) return 0;
    addr    = (row >> 3) * SCREEN_WIDTH + col;
    bitmask = 8'(1 << (row & 7));
    case (mode)
      MODE_SET:    frame_model[addr] = frame_model[addr] | bitmask;
      MODE_INVERT: frame_model[addr] = frame_model[addr] ^ bitmask;
      default:     frame_model[addr] = frame_model[addr] & ~bitmask;
    endcase
    return 1;
  endfunction

  // Walk the integer line; steep lines swap axes, and the walk always runs
  // towards the larger major coordinate
  function automatic int trace_line(int ax, int ay, int bx, int by, logic [1:0] mode);
    bit steep;
    int t;
    int dx;
    int dy;
    int err;
    int ystep;
    int v;
    int hits;
    steep = ((by < ay) ? ay - by : by - ay) > ((bx < ax) ? ax - bx : bx - ax);
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx    = bx - ax;
    dy    = (by < ay) ? ay - by : by - ay;
    err   = dx / 2;
    ystep = (ay < by) ? 1 : -1;
    v     = ay;
    hits  = 0;
    for (int u = ax; u <= bx; u++) begin
      hits += steep ? paint_pixel(v, u, mode) : paint_pixel(u, v, mode);
      err -= dy;
      if (err < 0) begin
        v   += ystep;
        err += dx;
      end
    end
    return (hits > 255) ? 255 : hits;
  endfunction

  // Update the shadow store for one beat and return the result it must produce
  function automatic reply_t run_command(job_t j);
    reply_t r;
    r.read_byte = 8'h00;
    r.pixels    = 8'h00;
    case (j.kind)
      KIND_DRAW: begin
        r.pixels = 8'(trace_line(int'(j.xs), int'(j.ys), int'(j.xe), int'(j.ye), j.mode));
      end
      KIND_READ: begin
        if (int'(j.page) < PAGE_COUNT && int'(j.column) < SCREEN_WIDTH)
          r.read_byte = frame_model[int'(j.page) * SCREEN_WIDTH + int'(j.column)];
      end
      KIND_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = 8'h00;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic job_t blank_job(kind_e k);
    job_t j;
    j.kind   = k;
    j.xs     = '0;
    j.ys     = '0;
    j.xe     = '0;
    j.ye     = '0;
    j.mode   = MODE_CLEAR;
    j.page   = '0;
    j.column = '0;
    j.drain  = 1'b0;
    return j;
  endfunction

  function automatic job_t line_job(int xs, int ys, int xe, int ye, logic [1:0] mode);
    job_t j;
    j      = blank_job(KIND_DRAW);
    j.xs   = COORD_W'(xs);
    j.ys   = COORD_W'(ys);
    j.xe   = COORD_W'(xe);
    j.ye   = COORD_W'(ye);
    j.mode = mode;
    return j;
  endfunction

  function automatic job_t read_job(int page, int column);
    job_t j;
    j        = blank_job(KIND_READ);
    j.page   = 3'(page);
    j.column = 7'(column);
    return j;
  endfunction

  // Mostly lines that land on or near the screen, reads aimed at recent strokes,
  // the odd clear and spare kind; fields the kind ignores carry random bits
  function automatic job_t random_job();
    job_t j;
    int   pick;
    int   cx;
    int   cy;
    j.kind   = KIND_NOP;
    j.xs     = COORD_W'($urandom);
    j.ys     = COORD_W'($urandom);
    j.xe     = COORD_W'($urandom);
    j.ye     = COORD_W'($urandom);
    j.mode   = 2'($urandom);
    j.page   = 3'($urandom);
    j.column = 7'($urandom);
    j.drain  = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      j.kind = KIND_DRAW;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // across the screen with a thin off-screen margin
        j.xs = COORD_W'($urandom_range(0, SCREEN_WIDTH + 15) - 8);
        j.ys = COORD_W'($urandom_range(0, SCREEN_HEIGHT + 15) - 8);
        j.xe = COORD_W'($urandom_range(0, SCREEN_WIDTH + 15) - 8);
        j.ye = COORD_W'($urandom_range(0, SCREEN_HEIGHT + 15) - 8);
      end else if (pick < 9) begin
        // short stroke from an on-screen point, at times a single point
        cx = $urandom_range(0, SCREEN_WIDTH - 1);
        cy = $urandom_range(0, SCREEN_HEIGHT - 1);
        j.xs = COORD_W'(cx);
        j.ys = COORD_W'(cy);
        j.xe = COORD_W'(cx + int'($urandom_range(0, 6)) - 3);
        j.ye = COORD_W'(cy + int'($urandom_range(0, 6)) - 3);
      end
      pick = $urandom_range(0, 19);
      if (pick < 9) j.mode = MODE_SET;
      else if (pick < 15) j.mode = MODE_INVERT;
      else if (pick < 19) j.mode = MODE_CLEAR;
      else j.mode = MODE_SPARE;
      if (j.xe >= 0 && j.xe < SCREEN_WIDTH && j.ye >= 0 && j.ye < SCREEN_HEIGHT) begin
        last_x = int'(j.xe);
        last_y = int'(j.ye);
      end
    end else if (pick < 93) begin
      j.kind = KIND_READ;
      if ($urandom_range(0, 1) == 1) begin
        j.page   = 3'(last_y >> 3);
        j.column = 7'(last_x);
      end
    end else if (pick < 96) begin
      j.kind = KIND_CLEAR;
    end
    return j;
  endfunction

  // Stimulus: directed beats, then the random stream, then drain and judge
  initial begin
    job_t j;
    foreach (frame_model[i]) frame_model[i] = 8'h00;

    job_q.push_back(read_job(0, 0));                       // store starts cleared
    job_q.push_back(line_job(5, 5, 5, 5, MODE_SET));       // single point
    job_q.push_back(read_job(0, 5));
    job_q.push_back(line_job(0, 63, 127, 63, MODE_SET));   // full width, bottom row
    job_q.push_back(line_job(127, 0, 127, 63, MODE_INVERT));  // full height, last column
    job_q.push_back(line_job(100, 10, 20, 30, MODE_SET));  // start right of end
    job_q.push_back(line_job(10, 60, 14, 2, MODE_INVERT)); // steep, walked backwards
    job_q.push_back(line_job(-256, -256, -200, -100, MODE_SET));  // wholly off screen
    job_q.push_back(line_job(-256, 255, 255, -256, MODE_SPARE));  // extremes, spare mode
    job_q.push_back(line_job(255, 255, 255, 255, MODE_SET));
    job_q.push_back(line_job(-1, 0, 128, 0, MODE_CLEAR));  // clipped at both ends
    job_q.push_back(read_job(7, 127));
    job_q.push_back(read_job(7, 0));
    job_q.push_back(read_job(0, 127));
    j = blank_job(KIND_NOP);                               // spare kind, every field ones
    j.xs = '1; j.ys = '1; j.xe = '1; j.ye = '1;
    j.mode = '1; j.page = '1; j.column = '1;
    job_q.push_back(j);
    job_q.push_back(line_job(5, 5, 5, 5, MODE_INVERT));
    job_q.push_back(read_job(0, 5));
    j = blank_job(KIND_CLEAR);
    j.drain = 1'b1;
    job_q.push_back(j);
    job_q.push_back(read_job(7, 127));
    j = line_job(0, 0, 127, 63, MODE_SET);
    j.drain = 1'b1;
    job_q.push_back(j);
    job_q.push_back(read_job(3, 60));

    for (int n = 0; n < RANDOM_JOBS; n++) begin
      j = random_job();
      if (n % 150 == 75) j.drain = 1'b1;
      job_q.push_back(j);
    end
    jobs_total = job_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (jobs_taken != jobs_total) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Driver: present beats on the falling edge, hold each one until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (job_q.size() != 0 && !(job_q[0].drain && due_results.size() != 0)) begin
          live_job = job_q.pop_front();
          s_axis_tdata <= {live_job.column, live_job.page, live_job.mode,
                           live_job.ye, live_job.xe, live_job.ys, live_job.xs};
          s_axis_tuser  <= live_job.kind;
          s_axis_tvalid <= 1'b1;
          // flip now and then into a stretch of back-to-back beats
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall per result, sometimes counted from the last beat and sometimes
  // only while a result waits; twice hold off long enough for the front to back up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_gap      = rx_burst ? 0 : $urandom_range(0, 11);
        rx_on_valid = ($urandom_range(0, 1) == 1);
        if (results_seen == 200 || results_seen == 520) hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0 && (!rx_on_valid || m_axis_tvalid)) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (rx_gap == 0);
      end
    end
  end

  // Monitor: check the result beat against the oldest expectation before the
  // input beat of the same edge adds its own
  always @(posedge clk_i) begin
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        results_seen++;
        if (due_results.size() == 0) begin
          flag_error($sformatf("result beat %0d with nothing expected, tdata %h",
                               results_seen, m_axis_tdata));
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[7:0] !== want.read_byte)
            flag_error($sformatf("result %0d read_byte %h, want %h",
                                 results_seen, m_axis_tdata[7:0], want.read_byte));
          if (m_axis_tdata[15:8] !== want.pixels)
            flag_error($sformatf("result %0d pixels_written %0d, want %0d",
                                 results_seen, m_axis_tdata[15:8], want.pixels));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        jobs_taken++;
        due_results.push_back(run_command(live_job));
      end
    end
  end

endmodule
